>>> src/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the next cycle, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication checked in the same cycle, disabled in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle, also during reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/slvn_pkg.sv
package slvn_pkg;

    localparam int COORD_W = 32;
    localparam int NOISE_W = 36;
    localparam int LANES   = 9;
    localparam int STAGES  = 7;

    typedef logic [COORD_W-1:0] t_word;
    typedef logic [LANES-1:0][COORD_W-1:0] t_lanes;

    localparam t_word HASH_ROW_MUL = 32'd57;
    localparam int    HASH_SHIFT   = 13;
    localparam t_word HASH_SQ_MUL  = 32'd60493;
    localparam t_word HASH_LIN_ADD = 32'd19990303;
    localparam t_word HASH_OFFSET  = 32'd1376312589;
    localparam t_word HASH_MASK    = 32'h7fff_ffff;
    localparam t_word UNIT_ONE     = 32'h4000_0000;

    localparam logic signed [NOISE_W-1:0] NOISE_MIN = -36'sd17179869168;
    localparam logic signed [NOISE_W-1:0] NOISE_MAX = 36'sd17179869184;

    // lane numbering, row-major over the 3x3 neighbourhood
    localparam int LN_NW = 0;
    localparam int LN_N  = 1;
    localparam int LN_NE = 2;
    localparam int LN_W  = 3;
    localparam int LN_C  = 4;
    localparam int LN_E  = 5;
    localparam int LN_SW = 6;
    localparam int LN_S  = 7;
    localparam int LN_SE = 8;

    localparam t_word LANE_DX [LANES] = '{
        32'hffff_ffff, 32'd0, 32'd1,
        32'hffff_ffff, 32'd0, 32'd1,
        32'hffff_ffff, 32'd0, 32'd1
    };
    localparam t_word LANE_DY [LANES] = '{
        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
        32'd0,         32'd0,         32'd0,
        32'd1,         32'd1,         32'd1
    };

endpackage

>>> src/smoothed_lattice_value_noise.sv
// channel  dir  handshake                  payload
// in       in   i_in_valid / o_in_ready    i_x_coord, i_y_coord (signed 32)
// out      out  o_out_valid / i_out_ready  o_noise_value (signed 36)
//
// one word accepted per cycle while the output is not stalled
// nine hash lanes run side by side through a 7-stage pipeline, at most one
// 32-bit multiply per stage and none in the last three, so one word per cycle unless stalled
// synchronous active-low reset empties the pipeline; payload is not reset
// a stalled output holds its word, and bubbles inside the pipe still fill
// while the output waits
module smoothed_lattice_value_noise
    import slvn_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic signed [COORD_W-1:0] i_y_coord,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [NOISE_W-1:0] o_noise_value
);

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] stg_rdy;
    logic [STAGES-1:0] stg_ld;

    t_lanes r_n0, r_n1, r_n2;
    t_lanes r_sq, r_t, r_prod, r_v;
    t_lanes n_n0, n_sq, n_t, n_prod, n_v;

    logic signed [COORD_W+1:0] r_csum, r_ssum, n_csum, n_ssum;
    logic signed [COORD_W-1:0] r_ctr;
    logic signed [NOISE_W-1:0] r_out, n_out;

    // backwards ready chain: a stage takes a word when empty or when it drains
    always_comb begin
        stg_rdy[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int k = STAGES-2; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
        stg_ld[0] = stg_rdy[0] && i_in_valid;
        for (int k = 1; k < STAGES; k++) begin
            stg_ld[k] = stg_rdy[k] && r_vld[k-1];
        end
    end

    assign o_in_ready    = stg_rdy[0];
    assign o_out_valid   = r_vld[STAGES-1];
    assign o_noise_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (stg_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // per-lane hash datapath
    always_comb begin
        t_word px, py, row, n;
        for (int i = 0; i < LANES; i++) begin
            px        = t_word'(i_x_coord) + LANE_DX[i];
            py        = t_word'(i_y_coord) + LANE_DY[i];
            row       = py * HASH_ROW_MUL;
            n         = px + row;
            n_n0[i]   = n ^ (n << HASH_SHIFT);
            n_sq[i]   = r_n0[i] * r_n0[i];
            n_t[i]    = r_sq[i] * HASH_SQ_MUL;
            n_prod[i] = r_n2[i] * (r_t[i] + HASH_LIN_ADD);
            n_v[i]    = UNIT_ONE - ((r_prod[i] + HASH_OFFSET) & HASH_MASK);
        end
    end

    // weighted sum in two steps: group sums, then the final weighting
    always_comb begin
        n_csum = (COORD_W+2)'($signed(r_v[LN_NW])) + (COORD_W+2)'($signed(r_v[LN_NE]))
               + (COORD_W+2)'($signed(r_v[LN_SW])) + (COORD_W+2)'($signed(r_v[LN_SE]));
        n_ssum = (COORD_W+2)'($signed(r_v[LN_N])) + (COORD_W+2)'($signed(r_v[LN_W]))
               + (COORD_W+2)'($signed(r_v[LN_E])) + (COORD_W+2)'($signed(r_v[LN_S]));
        n_out  = NOISE_W'(r_csum) + (NOISE_W'(r_ssum) <<< 1) + (NOISE_W'(r_ctr) <<< 2);
    end

    always_ff @(posedge i_clk) begin
        if (stg_ld[0]) begin
            r_n0 <= n_n0;
        end
        if (stg_ld[1]) begin
            r_sq <= n_sq;
            r_n1 <= r_n0;
        end
        if (stg_ld[2]) begin
            r_t  <= n_t;
            r_n2 <= r_n1;
        end
        if (stg_ld[3]) begin
            r_prod <= n_prod;
        end
        if (stg_ld[4]) begin
            r_v <= n_v;
        end
        if (stg_ld[5]) begin
            r_csum <= n_csum;
            r_ssum <= n_ssum;
            r_ctr  <= $signed(r_v[LN_C]);
        end
        if (stg_ld[6]) begin
            r_out <= n_out;
        end
    end

endmodule

>>> src/slvn_checker.sv
`include "assert_macros.svh"

module slvn_checker
    import slvn_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic signed [COORD_W-1:0] i_x_coord,
    input logic signed [COORD_W-1:0] i_y_coord,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic signed [NOISE_W-1:0] o_noise_value
);

    // reset leaves no word at the output
    `ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_out_valid, "output valid after reset")

    // an empty output stage means the whole pipe can take a word
    `ASSERT_SAME(a_ready_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input blocked while output empty")

    // weighted sum stays inside its exact range
    `ASSERT_SAME(a_range, i_clk, i_rst_n, o_out_valid, (o_noise_value >= NOISE_MIN) && (o_noise_value <= NOISE_MAX), "noise value out of range")

    // stalled output word holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_noise_value), "stalled output word changed")

endmodule

bind smoothed_lattice_value_noise slvn_checker u_slvn_checker (.*);
